FILE: src/ypid_pkg.sv
// Shared types, constants and microcode program for the yaw steering controller.
package ypid_pkg;

  // Fixed-point formats
  localparam int ANGLE_FRAC_BITS  = 8;
  localparam int GAIN_FRAC_BITS   = 8;
  localparam int PERIOD_FRAC_BITS = 16;
  localparam int MAG_SHIFT        = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;

  // Field and datapath widths
  localparam int YAW_W   = 17;
  localparam int GAIN_W  = 16;
  localparam int SPEED_W = 16;
  localparam int CMD_W   = 3;
  localparam int ERR_W   = 20;
  localparam int U_W     = 48;
  localparam int ACC_W   = 56;
  localparam int COEF_W  = 34;
  localparam int MUL_A_W = COEF_W + 1;
  localparam int PROD_W  = MUL_A_W + ERR_W;
  localparam int QUO_W   = GAIN_W + PERIOD_FRAC_BITS;
  localparam int MAG_W   = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef logic signed [YAW_W-1:0]  yaw_t;
  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic        [GAIN_W-1:0] gain_t;
  typedef logic        [SPEED_W-1:0] speed_t;
  typedef logic        [CMD_W-1:0]  cmd_t;
  typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

  // Motor commands
  localparam cmd_t CMD_NONE  = 3'd0;
  localparam cmd_t CMD_RUN   = 3'd1;
  localparam cmd_t CMD_STOP  = 3'd2;
  localparam cmd_t CMD_RIGHT = 3'd3;
  localparam cmd_t CMD_LEFT  = 3'd4;

  // Request opcodes
  localparam logic OPC_SAMPLE = 1'b0;
  localparam logic OPC_CLEAR  = 1'b1;

  // Register indexes
  localparam cfg_idx_t REG_TARGET_YAW     = 3'd0;
  localparam cfg_idx_t REG_GAIN_P         = 3'd1;
  localparam cfg_idx_t REG_GAIN_I         = 3'd2;
  localparam cfg_idx_t REG_GAIN_D         = 3'd3;
  localparam cfg_idx_t REG_SAMPLE_PERIOD  = 3'd4;
  localparam cfg_idx_t REG_RUN_ENABLE     = 3'd5;
  localparam cfg_idx_t REG_CRUISE_SPEED   = 3'd6;
  localparam cfg_idx_t REG_EXTERNAL_SPEED = 3'd7;

  // Register reset values
  localparam gain_t  RST_GAIN_P = 16'd256;
  localparam gain_t  RST_PERIOD = 16'd6554;

  // Angle thresholds, all in the error format
  localparam err_t ALLOW_ERR   = err_t'(2 << ANGLE_FRAC_BITS);
  localparam err_t NEG_ALLOW   = err_t'(-(2 << ANGLE_FRAC_BITS));
  localparam err_t RUN_RIGHT   = err_t'(-(1 << ANGLE_FRAC_BITS));
  localparam err_t SEAM_OFFSET = err_t'(162 << ANGLE_FRAC_BITS);
  localparam err_t SEAM_LIMIT  = err_t'(5 << ANGLE_FRAC_BITS);
  localparam err_t SEAM_YAW    = err_t'(100 << ANGLE_FRAC_BITS);
  localparam err_t FULL_TURN   = err_t'(360 << ANGLE_FRAC_BITS);

  // Speed constants
  localparam logic [MAG_W-1:0] SPEED_LIMIT = 10'd800;
  localparam speed_t IDLE_BASE_SPEED = 16'd1400;

  // Microcode fields
  localparam int STEP_W = 5;
  localparam int COND_W = 3;
  localparam int OP_W   = 4;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [COND_W-1:0] cond_t;
  typedef logic [OP_W-1:0]   op_t;

  typedef struct packed {
    cond_t cond;
    logic  hold;
    step_t target;
    op_t   op;
  } ucode_t;

  // Jump conditions
  localparam cond_t COND_NEXT     = 3'd0;
  localparam cond_t COND_ALWAYS   = 3'd1;
  localparam cond_t COND_REQ      = 3'd2;
  localparam cond_t COND_CLEAR    = 3'd3;
  localparam cond_t COND_BAND     = 3'd4;
  localparam cond_t COND_COEF_OK  = 3'd5;
  localparam cond_t COND_DIV_DONE = 3'd6;
  localparam cond_t COND_OUT_FREE = 3'd7;

  // Datapath operations
  localparam op_t OP_NOP  = 4'd0;
  localparam op_t OP_ERR  = 4'd1;
  localparam op_t OP_KI   = 4'd2;
  localparam op_t OP_KIT  = 4'd3;
  localparam op_t OP_COEF = 4'd4;
  localparam op_t OP_M0   = 4'd5;
  localparam op_t OP_M1   = 4'd6;
  localparam op_t OP_M2   = 4'd7;
  localparam op_t OP_M3   = 4'd8;
  localparam op_t OP_SAT  = 4'd9;
  localparam op_t OP_MAG  = 4'd10;
  localparam op_t OP_RES  = 4'd11;
  localparam op_t OP_BAND = 4'd12;
  localparam op_t OP_CLR  = 4'd13;
  localparam op_t OP_EMIT = 4'd14;

  // Program addresses
  localparam step_t STEP_FETCH   = 5'd0;
  localparam step_t STEP_DEC     = 5'd1;
  localparam step_t STEP_BANDCHK = 5'd2;
  localparam step_t STEP_COEFCHK = 5'd3;
  localparam step_t STEP_KI      = 5'd4;
  localparam step_t STEP_KIT     = 5'd5;
  localparam step_t STEP_DIVWAIT = 5'd6;
  localparam step_t STEP_COEF    = 5'd7;
  localparam step_t STEP_MAC0    = 5'd8;
  localparam step_t STEP_MAC1    = 5'd9;
  localparam step_t STEP_MAC2    = 5'd10;
  localparam step_t STEP_MAC3    = 5'd11;
  localparam step_t STEP_SAT     = 5'd12;
  localparam step_t STEP_MAG     = 5'd13;
  localparam step_t STEP_RES     = 5'd14;
  localparam step_t STEP_BAND    = 5'd15;
  localparam step_t STEP_CLR     = 5'd16;
  localparam step_t STEP_EMIT    = 5'd17;

  // Control store: on a true condition jump to target, else hold or advance
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '{cond: COND_ALWAYS, hold: 1'b0, target: STEP_FETCH, op: OP_NOP};
    case (step)
      STEP_FETCH:   w = '{COND_REQ,      1'b1, STEP_DEC,   OP_NOP};
      STEP_DEC:     w = '{COND_CLEAR,    1'b0, STEP_CLR,   OP_ERR};
      STEP_BANDCHK: w = '{COND_BAND,     1'b0, STEP_BAND,  OP_NOP};
      STEP_COEFCHK: w = '{COND_COEF_OK,  1'b0, STEP_MAC0,  OP_NOP};
      STEP_KI:      w = '{COND_NEXT,     1'b0, STEP_FETCH, OP_KI};
      STEP_KIT:     w = '{COND_NEXT,     1'b0, STEP_FETCH, OP_KIT};
      STEP_DIVWAIT: w = '{COND_DIV_DONE, 1'b1, STEP_COEF,  OP_NOP};
      STEP_COEF:    w = '{COND_NEXT,     1'b0, STEP_FETCH, OP_COEF};
      STEP_MAC0:    w = '{COND_NEXT,     1'b0, STEP_FETCH, OP_M0};
      STEP_MAC1:    w = '{COND_NEXT,     1'b0, STEP_FETCH, OP_M1};
      STEP_MAC2:    w = '{COND_NEXT,     1'b0, STEP_FETCH, OP_M2};
      STEP_MAC3:    w = '{COND_NEXT,     1'b0, STEP_FETCH, OP_M3};
      STEP_SAT:     w = '{COND_NEXT,     1'b0, STEP_FETCH, OP_SAT};
      STEP_MAG:     w = '{COND_NEXT,     1'b0, STEP_FETCH, OP_MAG};
      STEP_RES:     w = '{COND_ALWAYS,   1'b0, STEP_EMIT,  OP_RES};
      STEP_BAND:    w = '{COND_ALWAYS,   1'b0, STEP_EMIT,  OP_BAND};
      STEP_CLR:     w = '{COND_NEXT,     1'b0, STEP_FETCH, OP_CLR};
      STEP_EMIT:    w = '{COND_OUT_FREE, 1'b1, STEP_FETCH, OP_EMIT};
      default:      w = '{COND_ALWAYS,   1'b0, STEP_FETCH, OP_NOP};
    endcase
    return w;
  endfunction

endpackage

FILE: src/ypid_if.sv
// Handshake channels of the yaw steering controller: samples, results, register writes.
interface ypid_in_if import ypid_pkg::*; ();
  logic valid;
  logic ready;
  logic opcode;
  yaw_t measured_yaw;

  modport source (output valid, output opcode, output measured_yaw, input ready);
  modport sink (input valid, input opcode, input measured_yaw, output ready);
endinterface

interface ypid_out_if import ypid_pkg::*; ();
  logic   valid;
  logic   ready;
  cmd_t   motor_command;
  speed_t wheel_speed;

  modport source (output valid, output motor_command, output wheel_speed, input ready);
  modport sink (input valid, input motor_command, input wheel_speed, output ready);
endinterface

interface ypid_cfg_if import ypid_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/yaw_incremental_pid_steer.sv
// Top level: microcoded velocity-form PID yaw steering controller.
// Each request carries a yaw sample or a clear opcode and yields one motor command with a
// wheel speed. A small control store sequences one shared multiplier, an accumulator
// and a bit-serial divider. A sample taking the PID path uses the cached PID coefficients;
// the first such sample after reset, or after a write of gain_p, gain_i, gain_d or
// sample_period, rebuilds the coefficients through the divider before the
// multiply-accumulate. A sample inside the deadband and a clear request skip the PID path.
// The result sits in an output register, so the next request is taken while the previous
// result waits.
// Register writes are accepted every cycle and must only be issued while the block is idle.
module yaw_incremental_pid_steer import ypid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ypid_cfg_if.sink    cfg_ch,
  ypid_in_if.sink     in_ch,
  ypid_out_if.source  out_ch
);

  // Configuration registers
  yaw_t   tgt_r;
  gain_t  gp_r, gi_r, gd_r, per_r;
  logic   run_r;
  speed_t cruise_r, ext_r;
  logic   coef_ok_r;

  // Sequencer
  step_t  pc_r, pc_nxt;
  ucode_t uc;
  logic   cond_hit;

  // Request and PID state
  logic   op_r;
  yaw_t   yaw_r;
  err_t   err_r, e1_r, e2_r;
  logic signed [U_W-1:0] prev_r;

  // Datapath registers
  logic [GAIN_W-1:0]  kit_r;
  logic [QUO_W-1:0]   kdt_r;
  logic [COEF_W-1:0]  a0_r, a1_r;
  logic signed [MUL_A_W-1:0] mul_a;
  err_t                      mul_b;
  logic signed [PROD_W-1:0]  prod_nxt, prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [MAG_W-1:0]   mag_r;
  cmd_t   res_cmd_r;
  speed_t res_speed_r;

  // Output register
  logic   out_valid_r;
  cmd_t   out_cmd_r;
  speed_t out_speed_r;
  logic   out_free;

  // Combinational helpers
  logic   in_fire;
  err_t   yaw_x, tgt_x, dis, yaw_u, err_calc;
  logic   in_band, seam;
  gain_t  per_eff;
  logic   div_busy;
  logic [QUO_W-1:0] div_q;
  logic signed [U_W-1:0] u_sat;
  logic [U_W-1:0]   u_abs;
  logic [U_W-MAG_SHIFT-1:0] mag_full;
  speed_t spd_sum;
  cmd_t   pid_cmd;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (pc_r == STEP_FETCH);
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  // Register writes; gain or period writes invalidate the cached coefficients
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r    <= '0;
      gp_r     <= RST_GAIN_P;
      gi_r     <= '0;
      gd_r     <= '0;
      per_r    <= RST_PERIOD;
      run_r    <= 1'b0;
      cruise_r <= '0;
      ext_r    <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_TARGET_YAW:     tgt_r    <= cfg_ch.data[YAW_W-1:0];
        REG_GAIN_P:         gp_r     <= cfg_ch.data[GAIN_W-1:0];
        REG_GAIN_I:         gi_r     <= cfg_ch.data[GAIN_W-1:0];
        REG_GAIN_D:         gd_r     <= cfg_ch.data[GAIN_W-1:0];
        REG_SAMPLE_PERIOD:  per_r    <= cfg_ch.data[GAIN_W-1:0];
        REG_RUN_ENABLE:     run_r    <= cfg_ch.data[0];
        REG_CRUISE_SPEED:   cruise_r <= cfg_ch.data[SPEED_W-1:0];
        REG_EXTERNAL_SPEED: ext_r    <= cfg_ch.data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Evaluate the jump condition of the current control word
  assign uc = ucode_rom(pc_r);

  always_comb begin
    case (uc.cond)
      COND_NEXT:     cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_REQ:      cond_hit = in_ch.valid;
      COND_CLEAR:    cond_hit = (op_r == OPC_CLEAR);
      COND_BAND:     cond_hit = in_band;
      COND_COEF_OK:  cond_hit = coef_ok_r;
      COND_DIV_DONE: cond_hit = !div_busy;
      COND_OUT_FREE: cond_hit = out_free;
      default:       cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      pc_nxt = uc.target;
    end else if (uc.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  // Heading error, deadband and seam unwrap from the held sample
  always_comb begin
    yaw_x    = ERR_W'(yaw_r);
    tgt_x    = ERR_W'(tgt_r);
    dis      = yaw_x - tgt_x;
    in_band  = (dis < ALLOW_ERR) && (dis > NEG_ALLOW);
    seam     = ((tgt_x + SEAM_OFFSET) < SEAM_LIMIT) && (yaw_x > SEAM_YAW);
    yaw_u    = seam ? (yaw_x - FULL_TURN) : yaw_x;
    err_calc = yaw_u - tgt_x;
  end

  assign per_eff = (per_r == '0) ? GAIN_W'(1) : per_r;

  // Kd/T = gain_d * 2^16 / T
  ypid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (uc.op == OP_KI),
    .dividend ({gd_r, PERIOD_FRAC_BITS'(0)}),
    .divisor  (per_eff),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Select the shared multiplier operands
  always_comb begin
    case (uc.op)
      OP_KI: begin
        mul_a = MUL_A_W'(gi_r);
        mul_b = ERR_W'(per_eff);
      end
      OP_M0: begin
        mul_a = MUL_A_W'(a0_r);
        mul_b = err_r;
      end
      OP_M1: begin
        mul_a = MUL_A_W'(a1_r);
        mul_b = e1_r;
      end
      OP_M2: begin
        mul_a = MUL_A_W'(kdt_r);
        mul_b = e2_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Saturate the accumulator to the stored output width
  always_comb begin
    if (!acc_r[ACC_W-1] && (|acc_r[ACC_W-2:U_W-1])) begin
      u_sat = {1'b0, {(U_W-1){1'b1}}};
    end else if (acc_r[ACC_W-1] && !(&acc_r[ACC_W-2:U_W-1])) begin
      u_sat = {1'b1, {(U_W-1){1'b0}}};
    end else begin
      u_sat = acc_r[U_W-1:0];
    end
  end

  // Magnitude of the PID output in speed units
  assign u_abs    = prev_r[U_W-1] ? (~prev_r + U_W'(1)) : prev_r;
  assign mag_full = u_abs[U_W-1:MAG_SHIFT];

  // Spin direction and speed from the error and magnitude
  always_comb begin
    spd_sum = SPEED_W'(mag_r) + (run_r ? ext_r : IDLE_BASE_SPEED);
    if (run_r) begin
      pid_cmd = (err_r > RUN_RIGHT) ? CMD_RIGHT : CMD_LEFT;
    end else if (err_r > ALLOW_ERR) begin
      pid_cmd = CMD_RIGHT;
    end else if (err_r < NEG_ALLOW) begin
      pid_cmd = CMD_LEFT;
    end else begin
      pid_cmd = CMD_NONE;
    end
  end

  // Control state: step counter, PID history, coefficient cache, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_FETCH;
      prev_r      <= '0;
      e1_r        <= '0;
      e2_r        <= '0;
      coef_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (uc.op == OP_SAT) begin
        prev_r <= u_sat;
        e2_r   <= e1_r;
        e1_r   <= err_r;
      end else if (uc.op == OP_CLR) begin
        prev_r <= '0;
      end
      if (cfg_ch.valid && (cfg_ch.index inside {REG_GAIN_P, REG_GAIN_I, REG_GAIN_D,
                                                REG_SAMPLE_PERIOD})) begin
        coef_ok_r <= 1'b0;
      end else if (uc.op == OP_COEF) begin
        coef_ok_r <= 1'b1;
      end
      if (uc.op == OP_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers driven by the control word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_ch.opcode;
      yaw_r <= in_ch.measured_yaw;
    end
    if (uc.op == OP_KI || uc.op == OP_M0 || uc.op == OP_M1 || uc.op == OP_M2) begin
      prod_r <= prod_nxt;
    end
    case (uc.op)
      OP_ERR:  err_r <= err_calc;
      OP_KIT:  kit_r <= prod_r[PERIOD_FRAC_BITS +: GAIN_W];
      OP_COEF: begin
        kdt_r <= div_q;
        a0_r  <= COEF_W'(gp_r) + COEF_W'(kit_r) + COEF_W'(div_q);
        a1_r  <= COEF_W'(gp_r) + COEF_W'({div_q, 1'b0});
      end
      OP_M1:   acc_r <= ACC_W'(prev_r) + ACC_W'(prod_r);
      OP_M2:   acc_r <= acc_r - ACC_W'(prod_r);
      OP_M3:   acc_r <= acc_r + ACC_W'(prod_r);
      OP_MAG:  mag_r <= (mag_full > (U_W-MAG_SHIFT)'(SPEED_LIMIT)) ? SPEED_LIMIT
                                                                   : mag_full[MAG_W-1:0];
      OP_RES: begin
        res_cmd_r   <= pid_cmd;
        res_speed_r <= (pid_cmd == CMD_NONE) ? '0 : spd_sum;
      end
      OP_BAND: begin
        res_cmd_r   <= run_r ? CMD_RUN : CMD_STOP;
        res_speed_r <= run_r ? cruise_r : '0;
      end
      OP_CLR: begin
        res_cmd_r   <= CMD_NONE;
        res_speed_r <= '0;
      end
      default: ;
    endcase
    if (uc.op == OP_EMIT && out_free) begin
      out_cmd_r   <= res_cmd_r;
      out_speed_r <= res_speed_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.motor_command = out_cmd_r;
  assign out_ch.wheel_speed   = out_speed_r;

`ifndef SYNTHESIS
  // A request always moves the program to decode
  a_fire_dec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pc_r == STEP_DEC)
    else $error("accepted request did not enter decode");

  // A new result appears only from the emit step
  a_rose_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pc_r == STEP_EMIT))
    else $error("result raised outside the emit step");

  // The multiply-accumulate runs only on valid coefficients
  a_mac_coef: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == STEP_MAC0 |-> coef_ok_r)
    else $error("PID product started with stale coefficients");

  // The divider is idle whenever it is started
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    uc.op == OP_KI |-> !div_busy)
    else $error("divider restarted while busy");
`endif

endmodule

FILE: src/ypid_div.sv
// Restoring divider, one quotient bit per cycle, for the derivative coefficient.
module ypid_div import ypid_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [QUO_W-1:0]  dividend,
  input  gain_t             divisor,
  output logic              busy,
  output logic [QUO_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(QUO_W);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [GAIN_W-1:0] rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic [GAIN_W:0]   part;
  logic [GAIN_W+1:0] trial;

  // Trial subtract of the divisor from the shifted partial remainder
  assign part  = {rem_r, quo_r[QUO_W-1]};
  assign trial = {1'b0, part} - {2'b00, divisor};

  // Advance the iteration count
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W - 1);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      if (trial[GAIN_W+1]) begin
        rem_r <= part[GAIN_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], 1'b0};
      end else begin
        rem_r <= trial[GAIN_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], 1'b1};
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule
